### sv/ycbcr_to_argb_frame_converter_top_assert.svh
// Assertion helpers shared by the RTL files.
// Each macro checks one implication on the rising edge of clk, with the
// check held off while rst_n is low.
`ifndef YCBCR_TO_ARGB_FRAME_CONVERTER_TOP_ASSERT_SVH
`define YCBCR_TO_ARGB_FRAME_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define YC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define YC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ycbcr2argb_pkg.sv
// ---------------------------------------------------------------------------
// ycbcr2argb_pkg
// Shared widths, register indexes and payload types of the color converter.
// ---------------------------------------------------------------------------
package ycbcr2argb_pkg;

  // Width of the frame dimension registers and the row counter.
  localparam int DIM_BITS  = 12;
  localparam int COL_W     = DIM_BITS - 2;      // group column counter
  localparam int GRP_W     = DIM_BITS - 1;      // groups per row, up to 2^(DIM_BITS-2)
  localparam int OFS_W     = 2 * DIM_BITS + 1;  // word offset of the row start
  localparam int WADDR_W   = OFS_W + 1;         // word offset plus column words
  localparam int ADDR_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE   = 2'd3;

  localparam logic [7:0] CHROMA_OFFSET = 8'h80;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

  typedef struct packed {
    logic [7:0] luma0;
    logic [7:0] luma1;
    logic [7:0] luma2;
    logic [7:0] luma3;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel0;
    logic [31:0] pixel1;
    logic [31:0] pixel2;
    logic [31:0] pixel3;
    logic [31:0] dest_address;
    logic        frame_end;
  } out_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic [DIM_BITS-1:0] line_stride;
    logic [ADDR_W-1:0]   image_base;
  } cfg_t;

  // Chroma contributions to each channel, two's complement.
  typedef struct packed {
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } chroma_ofs_t;

  // Position of the current group in the destination buffer.
  typedef struct packed {
    logic [WADDR_W-1:0] word_addr;
    logic               frame_end;
  } addr_info_t;

endpackage

### sv/ycbcr2argb_cfg_regs.sv
// ---------------------------------------------------------------------------
// ycbcr2argb_cfg_regs
// Frame geometry and base address registers behind the write port.
// ---------------------------------------------------------------------------
module ycbcr2argb_cfg_regs
  import ycbcr2argb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg_nxt.frame_width  = cfg_data[DIM_BITS-1:0];
        REG_FRAME_HEIGHT: cfg_nxt.frame_height = cfg_data[DIM_BITS-1:0];
        REG_LINE_STRIDE:  cfg_nxt.line_stride  = cfg_data[DIM_BITS-1:0];
        REG_IMAGE_BASE:   cfg_nxt.image_base   = cfg_data[ADDR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/ycbcr2argb_addr_gen.sv
// ---------------------------------------------------------------------------
// ycbcr2argb_addr_gen
// Column, row and row-offset counters; word address and end-of-frame flag.
// ---------------------------------------------------------------------------
`include "ycbcr_to_argb_frame_converter_top_assert.svh"

module ycbcr2argb_addr_gen
  import ycbcr2argb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       advance,
  output addr_info_t info
);

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;

  logic [DIM_BITS:0]   width_up;
  logic [GRP_W-1:0]    groups;
  logic [COL_W:0]      col_inc;
  logic [DIM_BITS:0]   row_inc;
  logic [DIM_BITS-1:0] row_step;
  logic                row_end;
  logic                frame_end;

  always_comb begin
    width_up  = {1'b0, cfg.frame_width} + (DIM_BITS+1)'(3);
    groups    = width_up[DIM_BITS:2];
    col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
    row_inc   = {1'b0, row_r} + (DIM_BITS+1)'(1);
    row_end   = (col_inc >= groups);
    frame_end = row_end && (row_inc >= {1'b0, cfg.frame_height});
    row_step  = (cfg.frame_width > cfg.line_stride) ? cfg.frame_width : cfg.line_stride;

    info.word_addr = {1'b0, ofs_r} + {{(WADDR_W-COL_W-2){1'b0}}, col_r, 2'b00};
    info.frame_end = frame_end;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ofs_nxt = ofs_r;
    if (advance) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        ofs_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_inc[DIM_BITS-1:0];
        ofs_nxt = ofs_r + {{(OFS_W-DIM_BITS){1'b0}}, row_step};
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ofs_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ofs_r <= ofs_nxt;
    end
  end

  `YC_ASSERT_NEXT(a_frame_end_clears, advance && frame_end,
    col_r == '0 && row_r == '0 && ofs_r == '0, "counters not cleared at frame end")
  `YC_ASSERT_NEXT(a_hold_when_idle, !advance,
    $stable(col_r) && $stable(row_r) && $stable(ofs_r), "counters moved without an item")
  `YC_ASSERT_NEXT(a_row_start, advance && row_end, col_r == '0, "column not reset at row end")

endmodule

### sv/ycbcr2argb_chroma_calc.sv
// ---------------------------------------------------------------------------
// ycbcr2argb_chroma_calc
// Shift-add chroma contributions shared by the four pixels of a group.
// ---------------------------------------------------------------------------
module ycbcr2argb_chroma_calc
  import ycbcr2argb_pkg::*;
(
  input  logic [7:0]  chroma_blue,
  input  logic [7:0]  chroma_red,
  output chroma_ofs_t ofs
);

  logic signed [7:0] cb;
  logic signed [7:0] cr;

  // Sign-extend an 8-bit two's complement value.
  function automatic logic [9:0] sx(input logic [7:0] v);
    return {{2{v[7]}}, v};
  endfunction

  always_comb begin
    // Remove the 128 offset: flipping the top bit gives the signed value.
    cb = $signed(chroma_blue ^ CHROMA_OFFSET);
    cr = $signed(chroma_red ^ CHROMA_OFFSET);

    ofs.r = sx(cr) + sx(cr >>> 2) + sx(cr >>> 3) + sx(cr >>> 5);
    ofs.g = 10'd0 - (sx(cb >>> 2) + sx(cb >>> 4) + sx(cb >>> 5))
                  - (sx(cr >>> 1) + sx(cr >>> 3) + sx(cr >>> 4) + sx(cr >>> 5));
    ofs.b = sx(cb) + sx(cb >>> 1) + sx(cb >>> 2) + sx(cb >>> 6);
  end

endmodule

### sv/ycbcr2argb_pixel_pack.sv
// ---------------------------------------------------------------------------
// ycbcr2argb_pixel_pack
// Add luma to the chroma terms, clamp to 0..255 and pack one ARGB word.
// ---------------------------------------------------------------------------
module ycbcr2argb_pixel_pack
  import ycbcr2argb_pkg::*;
(
  input  logic [7:0]  luma,
  input  chroma_ofs_t ofs,
  output logic [31:0] pixel
);

  logic [10:0] r_sum;
  logic [10:0] g_sum;
  logic [10:0] b_sum;

  // Saturate an 11-bit two's complement value to 0..255.
  function automatic logic [7:0] clamp8(input logic [10:0] v);
    if (v[10]) begin
      return 8'd0;
    end else if (v[9:8] != 2'b00) begin
      return 8'hFF;
    end else begin
      return v[7:0];
    end
  endfunction

  always_comb begin
    r_sum = {3'b000, luma} + {ofs.r[9], ofs.r};
    g_sum = {3'b000, luma} + {ofs.g[9], ofs.g};
    b_sum = {3'b000, luma} + {ofs.b[9], ofs.b};
    pixel = {ALPHA_OPAQUE, clamp8(r_sum), clamp8(g_sum), clamp8(b_sum)};
  end

endmodule

### sv/ycbcr_to_argb_frame_converter_top.sv
// ---------------------------------------------------------------------------
// ycbcr_to_argb_frame_converter_top
// Four-pixel YCbCr to ARGB converter with destination address generation.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one item per four-pixel group (four luma, one Cb/Cr pair).
//   out_* : four packed 0xFF,R,G,B words, the byte address of the first
//           pixel, and a flag on the last group of the frame.
//   cfg_* : register writes (width, height, stride, base); always ready.
//           Write only while no item is in flight.
// From input accept to output valid an item passes two registers: the first
// holds the item with its chroma terms and word address, the second holds
// the finished result. Throughput is one item per cycle while out_ready
// stays high, and the address counters step as each item is accepted.
// While width or height is zero, items are taken and dropped, with no
// result and no counter change.
// Synchronous reset clears the registers, counters and both stages.
// When the receiver stalls, the result holds in the output register and
// stage 1 takes one more item if it is empty; then in_ready drops
// until out_ready returns.
// ---------------------------------------------------------------------------
`include "ycbcr_to_argb_frame_converter_top_assert.svh"

module ycbcr_to_argb_frame_converter_top
  import ycbcr2argb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t        cfg;
  addr_info_t  addr_info;
  chroma_ofs_t chroma_ofs;

  // Stage 1: registered item, chroma terms and word address.
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_luma_r [4];
  chroma_ofs_t s1_ofs_r;
  addr_info_t  s1_info_r;

  // Stage 2: result register.
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;

  logic        s2_load;
  logic        s1_move;
  logic        in_acc;
  logic        frame_live;
  logic        advance;
  logic [31:0] pix [4];
  logic [31:0] byte_ofs;

  ycbcr2argb_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ycbcr2argb_addr_gen u_addr_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .info    (addr_info)
  );

  ycbcr2argb_chroma_calc u_chroma_calc (
    .chroma_blue (in_data.chroma_blue),
    .chroma_red  (in_data.chroma_red),
    .ofs         (chroma_ofs)
  );

  for (genvar i = 0; i < 4; i++) begin : g_pix
    ycbcr2argb_pixel_pack u_pixel_pack (
      .luma  (s1_luma_r[i]),
      .ofs   (s1_ofs_r),
      .pixel (pix[i])
    );
  end

  // Handshake: the output register loads when empty or being drained;
  // stage 1 takes a new item when empty or moving forward.
  always_comb begin
    s2_load    = !out_valid_r || out_ready;
    s1_move    = s1_valid_r && s2_load;
    in_ready   = !s1_valid_r || s2_load;
    in_acc     = in_valid && in_ready;
    frame_live = (cfg.frame_width != '0) && (cfg.frame_height != '0);
    advance    = in_acc && frame_live;
  end

  always_comb begin
    // Drop items taken while the frame is empty.
    if (in_acc) begin
      s1_valid_nxt = frame_live;
    end else begin
      s1_valid_nxt = s1_valid_r && !s2_load;
    end
    if (s2_load) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the item with its chroma terms and position.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_luma_r[0] <= in_data.luma0;
      s1_luma_r[1] <= in_data.luma1;
      s1_luma_r[2] <= in_data.luma2;
      s1_luma_r[3] <= in_data.luma3;
      s1_ofs_r     <= chroma_ofs;
      s1_info_r    <= addr_info;
    end
  end

  // Byte address: base plus four times the word address, modulo 2^32.
  assign byte_ofs = 32'({s1_info_r.word_addr, 2'b00});

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r.pixel0       <= pix[0];
      out_r.pixel1       <= pix[1];
      out_r.pixel2       <= pix[2];
      out_r.pixel3       <= pix[3];
      out_r.dest_address <= cfg.image_base + byte_ofs;
      out_r.frame_end    <= s1_info_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `YC_ASSERT_NEXT(a_empty_frame_drop, in_acc && !frame_live, !s1_valid_r,
    "item kept while the frame is empty")
  `YC_ASSERT_NEXT(a_stage_to_output, s1_move, out_valid_r,
    "stage 1 item lost on its way to the output")
  `YC_ASSERT_NOW(a_stall_blocks_move, out_valid_r && !out_ready, !s1_move,
    "stage 1 moved into a stalled output")
  `YC_ASSERT_NEXT(a_full_pipe_holds, s1_valid_r && out_valid_r && !out_ready,
    s1_valid_r, "stage 1 item dropped during a stall")

endmodule

### tb/tb_ycbcr_to_argb_frame_converter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ycbcr_to_argb_frame_converter_top
// Self-checking bench for the four-pixel YCbCr to ARGB frame converter.
// Drives items through the valid/ready input with random bursts and gaps,
// stalls the result side in several patterns, and predicts every result
// (pixel words, destination address, end-of-frame flag) from a behavioral
// copy of the converter. Directed cases cover color extremes, empty frames,
// counters left past the end by register changes, and register extremes.
// A long random run follows over many frame settings.
// ---------------------------------------------------------------------------
module tb_ycbcr_to_argb_frame_converter_top;
  import ycbcr2argb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_GROUPS = 700;
  // Cycles to wait after the last expected result, so that any unexpected
  // result still in the two pipeline registers comes out and is flagged.
  localparam int FLUSH_CYCLES = 6;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_RUNS
  } ready_mode_t;

  // DUT ports; every input starts at a known value.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [31:0]          cfg_data = '0;

  // Predictor state: register shadow plus the position counters.
  cfg_t                 dest_cfg = '0;
  logic [COL_W-1:0]     group_col = '0;
  logic [DIM_BITS-1:0]  row_num = '0;
  logic [OFS_W-1:0]     row_offset = '0;

  out_item_t            expected_argb_q[$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;

  // Sender and receiver idling controls.
  bit                   sender_gaps = 1'b0;
  int                   burst_left = 0;
  ready_mode_t          ready_mode = READY_ALWAYS;
  logic [15:0]          ready_pattern = 16'hFFFF;
  logic [3:0]           pattern_pos = '0;
  int                   run_left = 0;

  // Checker scratch.
  out_item_t            head_argb;
  string                field_diffs;

  ycbcr_to_argb_frame_converter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Saturate a channel sum to one byte.
  function automatic logic [7:0] sat8(input int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return 8'(v);
  endfunction

  // Convert one pixel; chroma arrives already centered. The >>> on int
  // is a floor shift, which matches the hardware's arithmetic shifts.
  function automatic logic [31:0] argb_word(input int y, input int cb, input int cr);
    int r;
    int g;
    int b;
    r = y + cr + (cr >>> 2) + (cr >>> 3) + (cr >>> 5);
    g = y - ((cb >>> 2) + (cb >>> 4) + (cb >>> 5))
          - ((cr >>> 1) + (cr >>> 3) + (cr >>> 4) + (cr >>> 5));
    b = y + cb + (cb >>> 1) + (cb >>> 2) + (cb >>> 6);
    return {ALPHA_OPAQUE, sat8(r), sat8(g), sat8(b)};
  endfunction

  // Work out the result of one accepted item and advance the counters.
  // Returns 0 when the frame is empty and the item is dropped.
  function automatic bit convert_group(input in_item_t grp, output out_item_t res);
    int                  cb;
    int                  cr;
    int                  groups;
    bit                  row_end;
    bit                  last;
    logic [31:0]         word;
    logic [DIM_BITS-1:0] step;
    res = '0;
    if (dest_cfg.frame_width == '0 || dest_cfg.frame_height == '0) return 1'b0;
    cb = int'(grp.chroma_blue) - int'(CHROMA_OFFSET);
    cr = int'(grp.chroma_red) - int'(CHROMA_OFFSET);
    res.pixel0 = argb_word(int'(grp.luma0), cb, cr);
    res.pixel1 = argb_word(int'(grp.luma1), cb, cr);
    res.pixel2 = argb_word(int'(grp.luma2), cb, cr);
    res.pixel3 = argb_word(int'(grp.luma3), cb, cr);
    word = 32'(row_offset) + 32'(group_col) * 32'd4;
    res.dest_address = dest_cfg.image_base + (word << 2);
    groups  = (int'(dest_cfg.frame_width) + 3) >> 2;
    row_end = int'(group_col) + 1 >= groups;
    last    = row_end && (int'(row_num) + 1 >= int'(dest_cfg.frame_height));
    res.frame_end = last;
    if (last) begin
      group_col  = '0;
      row_num    = '0;
      row_offset = '0;
    end else if (row_end) begin
      step = (dest_cfg.frame_width > dest_cfg.line_stride) ?
             dest_cfg.frame_width : dest_cfg.line_stride;
      group_col  = '0;
      row_num    = row_num + 1'b1;
      row_offset = row_offset + step;
    end else begin
      group_col = group_col + 1'b1;
    end
    return 1'b1;
  endfunction

  // -------------------------------------------------------------------------
  // Shared drivers. All of them start and end on a falling edge.
  // -------------------------------------------------------------------------

  // Send one item; insert a gap at the end of each burst when gaps are on.
  // Record the expected result at the edge that accepts the item.
  task automatic send_group(input in_item_t grp);
    out_item_t want;
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data  <= grp;
    do @(posedge clk); while (!in_ready);
    if (convert_group(grp, want)) expected_argb_q.push_back(want);
    @(negedge clk);
  endtask

  // Write one register, then drop cfg_valid before returning so the next write
  // never lowers and raises cfg_valid on the same edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  dest_cfg.frame_width  = value[DIM_BITS-1:0];
      REG_FRAME_HEIGHT: dest_cfg.frame_height = value[DIM_BITS-1:0];
      REG_LINE_STRIDE:  dest_cfg.line_stride  = value[DIM_BITS-1:0];
      REG_IMAGE_BASE:   dest_cfg.image_base   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic [31:0] width, input logic [31:0] height,
                           input logic [31:0] stride, input logic [31:0] base);
    write_reg(REG_FRAME_WIDTH, width);
    write_reg(REG_FRAME_HEIGHT, height);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_IMAGE_BASE, base);
  endtask

  // Drop valid, wait for every expected result, then let any unexpected result
  // still in the pipeline drain before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_argb_q.size() != 0) @(negedge clk);
    repeat (FLUSH_CYCLES) @(negedge clk);
  endtask

  // Pick a new sender gap setting and receiver stall pattern.
  task automatic pick_idling();
    ready_mode    = ready_mode_t'($urandom_range(0, 3));
    ready_pattern = 16'($urandom) | 16'h0001;
    sender_gaps   = ($urandom_range(0, 3) != 0);
  endtask

  // Random byte, biased toward the ends and the middle of the range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_group();
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // Dimension register word with random junk above the twelve used bits now
  // and then; the block keeps only the low bits.
  function automatic logic [31:0] dim_word(input int v);
    logic [31:0] junk;
    junk = ($urandom_range(0, 2) == 0) ? ($urandom & 32'hFFFF_F000) : 32'h0;
    return junk | 32'(v);
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Registers are zero after reset: items are taken and dropped. Then try
  // a zero height with a nonzero width.
  task automatic test_empty_frame();
    ready_mode  = READY_ALWAYS;
    sender_gaps = 1'b0;
    send_group({8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60});
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    settle();
    set_frame(32'd8, 32'd0, 32'd8, 32'h0000_0100);
    send_group({8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});
    settle();
  endtask

  // One full 16 x 2 frame with stride wider than the image, so the second
  // row starts past the end-of-line skip. Colors hit both clamps.
  task automatic test_color_extremes();
    set_frame(32'd16, 32'd2, 32'd20, 32'h0000_1000);
    ready_mode  = READY_RANDOM;
    sender_gaps = 1'b1;
    send_group({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_group({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_group({8'h00, 8'h55, 8'hAA, 8'hFF, 8'h80, 8'h80});
    send_group({8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF});
    send_group({8'h10, 8'hEB, 8'h80, 8'h40, 8'hFF, 8'h00});
    send_group({8'h80, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h81});
    send_group({8'h01, 8'hFE, 8'h7F, 8'h80, 8'h01, 8'hFE});
    send_group({8'hC8, 8'h32, 8'h96, 8'h64, 8'h40, 8'hC0});
    settle();
  endtask

  // Shrink the width mid-row so the column is already past the last group,
  // then shrink the height mid-frame so the row is past the last row.
  // The base sits near the top of the address space so addresses wrap.
  task automatic test_counter_overrun();
    set_frame(32'd16, 32'd4, 32'd8, 32'hFFFF_FFF0);
    ready_mode  = READY_RUNS;
    sender_gaps = 1'b0;
    send_group({8'h20, 8'h40, 8'h60, 8'h80, 8'h90, 8'h70});
    send_group({8'hA0, 8'hB0, 8'hC0, 8'hD0, 8'h30, 8'hD0});
    settle();
    write_reg(REG_FRAME_WIDTH, 32'd4);
    send_group({8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66});
    send_group({8'h77, 8'h88, 8'h99, 8'hAA, 8'hBB, 8'hCC});
    settle();
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    send_group({8'hDD, 8'hEE, 8'hFF, 8'h00, 8'h12, 8'hED});
    settle();
  endtask

  // All-ones register words, which the dimension registers clip to 4095,
  // then a 1 x 1 frame where every item is the whole frame.
  task automatic test_config_extremes();
    set_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    ready_mode    = READY_PATTERN;
    ready_pattern = 16'b1010_0110_0001_1101;
    sender_gaps   = 1'b1;
    send_group({8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h80});
    send_group({8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h00, 8'hFF});
    send_group({8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    settle();
    set_frame(32'd1, 32'd1, 32'd0, 32'h0000_0000);
    send_group({8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC});
    send_group({8'hFE, 8'hDC, 8'hBA, 8'h98, 8'h76, 8'h54});
    settle();
  endtask

  // Phases of random items over random frame settings. Most frames are
  // small so rows and frames end often; a few use extreme registers, a few
  // are empty, and some rewrite one register mid-frame.
  task automatic test_random_frames();
    int sent;
    int n;
    int k;
    int pick;
    sent = 0;
    while (sent < RANDOM_GROUPS) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: set_frame(($urandom_range(0, 1) != 0) ? 32'd4095 : 32'd1,
                     ($urandom_range(0, 1) != 0) ? 32'd4095 : 32'd1,
                     ($urandom_range(0, 1) != 0) ? 32'd4095 : 32'd0,
                     ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0);
        1: begin
          if ($urandom_range(0, 1) != 0)
            set_frame(dim_word(0), dim_word($urandom_range(1, 6)),
                      dim_word($urandom_range(0, 32)), $urandom);
          else
            set_frame(dim_word($urandom_range(1, 24)), dim_word(0),
                      dim_word($urandom_range(0, 32)), $urandom);
        end
        2: begin
          k = $urandom_range(0, 3);
          if (k == 3) write_reg(REG_IMAGE_BASE, $urandom);
          else        write_reg(CFG_IDX_W'(k), dim_word($urandom_range(0, 24)));
        end
        default: set_frame(dim_word($urandom_range(1, 24)), dim_word($urandom_range(1, 6)),
                           dim_word($urandom_range(0, 32)), $urandom);
      endcase
      pick_idling();
      n = $urandom_range(20, 60);
      for (k = 0; k < n; k++) send_group(random_group());
      // Dropped items do not count toward the run length.
      if (dest_cfg.frame_width != '0 && dest_cfg.frame_height != '0) sent += n;
      settle();
    end
  endtask

  // -------------------------------------------------------------------------
  // Receiver: drive out_ready on the falling edge in the current mode.
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= ($urandom_range(0, 99) >= 35);
      READY_PATTERN: begin
        out_ready   <= ready_pattern[pattern_pos];
        pattern_pos <= pattern_pos + 1'b1;
      end
      default: begin
        // Alternate runs of stalls and of ready, of random lengths; stall runs can be longer.
        if (run_left == 0) begin
          out_ready <= ~out_ready;
          run_left  <= out_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation.
  // -------------------------------------------------------------------------
  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_argb_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: %p", out_data));
      end else begin
        head_argb   = expected_argb_q.pop_front();
        field_diffs = "";
        if (out_data.pixel0 !== head_argb.pixel0)
          field_diffs = {field_diffs, $sformatf(" pixel0 exp %h got %h",
                                                head_argb.pixel0, out_data.pixel0)};
        if (out_data.pixel1 !== head_argb.pixel1)
          field_diffs = {field_diffs, $sformatf(" pixel1 exp %h got %h",
                                                head_argb.pixel1, out_data.pixel1)};
        if (out_data.pixel2 !== head_argb.pixel2)
          field_diffs = {field_diffs, $sformatf(" pixel2 exp %h got %h",
                                                head_argb.pixel2, out_data.pixel2)};
        if (out_data.pixel3 !== head_argb.pixel3)
          field_diffs = {field_diffs, $sformatf(" pixel3 exp %h got %h",
                                                head_argb.pixel3, out_data.pixel3)};
        if (out_data.dest_address !== head_argb.dest_address)
          field_diffs = {field_diffs, $sformatf(" dest_address exp %h got %h",
                                                head_argb.dest_address,
                                                out_data.dest_address)};
        if (out_data.frame_end !== head_argb.frame_end)
          field_diffs = {field_diffs, $sformatf(" frame_end exp %b got %b",
                                                head_argb.frame_end, out_data.frame_end)};
        if (field_diffs != "") note_mismatch({"result differs:", field_diffs});
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence: hold reset, run each test, drain, report.
  // -------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_frame();
    test_color_extremes();
    test_counter_overrun();
    test_config_extremes();
    test_random_frames();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_argb_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/ycbcr2argb_pkg.sv
sv/ycbcr2argb_cfg_regs.sv
sv/ycbcr2argb_addr_gen.sv
sv/ycbcr2argb_chroma_calc.sv
sv/ycbcr2argb_pixel_pack.sv
sv/ycbcr_to_argb_frame_converter_top.sv
tb/tb_ycbcr_to_argb_frame_converter_top.sv
